// File: rtl/assert_macros.svh
// Assertion macros used by the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/trjq_pkg.sv
// Shared types and constants of the timestamp reorder jitter queue.
package trjq_pkg;
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int MAX_RUN         = 64;
    localparam int RUN_W           = 7;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_REORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXLEN  = 2'd2;

    localparam logic [15:0] RST_TIMEOUT = 16'd500;
    localparam logic [6:0]  RST_MAXLEN  = 7'd32;

    typedef struct packed {
        logic [31:0] dts;
        logic [23:0] len;
        logic        kind;
        logic [15:0] tag;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic set_anchor;
        logic dec_j;
        logic wr_shift;
        logic wr_new;
        logic rd_head;
        logic pop;
        logic load_pend;
        logic emit;
        logic emit_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic j_zero;
        logic greater;
        logic ready;
        logic pend_valid;
        logic out_busy;
        logic full;
        logic anchor_valid;
    } t_stat;
endpackage

// File: rtl/trjq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module trjq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/trjq_datapath.sv
// Datapath: ring-buffer table, item and anchor registers, readiness, output stage.
`include "assert_macros.svh"
module trjq_datapath import trjq_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [31:0]           i_packet_dts,
    input  logic [31:0]           i_now_time,
    input  logic [23:0]           i_packet_length,
    input  logic                  i_packet_kind,
    input  logic [15:0]           i_buffer_tag,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [31:0]           o_out_dts,
    output logic [23:0]           o_out_length,
    output logic                  o_out_kind,
    output logic [15:0]           o_out_tag,
    output logic                  o_last_of_run
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (CW > 7) ? CW : 7;
    localparam int EW = $bits(t_entry);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);
    localparam logic [LW-1:0] DEPTH_L  = LW'(TABLE_DEPTH);
    localparam logic [LW-1:0] TWO_L    = LW'(2);

    // Configuration registers
    logic        r_reorder;
    logic [15:0] r_timeout;
    logic [6:0]  r_maxlen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reorder <= 1'b1;
            r_timeout <= RST_TIMEOUT;
            r_maxlen  <= RST_MAXLEN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REORDER: r_reorder <= i_cfg_data[0];
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_MAXLEN:  r_maxlen  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Control state of the table
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_j;
    logic          r_anchor_valid;
    logic [31:0]   r_anchor_dts;
    logic [31:0]   r_anchor_time;
    t_entry        r_item;
    logic [31:0]   r_now;
    logic signed [33:0] r_elapsed;
    t_entry        r_pend;
    logic          r_pend_valid;
    t_entry        r_out;
    logic          r_out_last;
    logic          r_out_valid;

    t_entry        rdata;
    logic [EW-1:0] ram_rdata;
    logic [AW-1:0] rd_rel;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] head_next;

    // Map a position relative to the head onto a ring address
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                                input logic [AW-1:0] rel);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, rel};
        if (sum >= (AW+1)'(TABLE_DEPTH)) begin
            sum = sum - (AW+1)'(TABLE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign rd_rel    = i_cmd.rd_head ? '0 : (r_j - AW'(1));
    assign rd_addr   = ring_addr(r_head, rd_rel);
    assign wr_addr   = ring_addr(r_head, r_j);
    assign head_next = ring_addr(r_head, AW'(1));
    assign rdata     = t_entry'(ram_rdata);

    trjq_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_shift | i_cmd.wr_new),
        .i_waddr (wr_addr),
        .i_wdata (i_cmd.wr_new ? r_item : rdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Track count, head and anchor valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_head         <= '0;
            r_anchor_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_new) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
                r_head  <= head_next;
            end
            if (i_cmd.set_anchor) begin
                r_anchor_valid <= 1'b1;
            end
        end
    end

    // Hold the request, the insert position, the anchor and the elapsed local time
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= '{dts: i_packet_dts, len: i_packet_length,
                        kind: i_packet_kind, tag: i_buffer_tag};
            r_now  <= i_now_time;
            r_j    <= r_count[AW-1:0];
        end else if (i_cmd.dec_j) begin
            r_j <= r_j - AW'(1);
        end
        if (i_cmd.set_anchor) begin
            r_anchor_dts  <= i_packet_dts;
            r_anchor_time <= i_now_time;
        end
        r_elapsed <= $signed({2'b00, r_now}) - $signed({2'b00, r_anchor_time});
    end

    // Decide whether the head may leave
    logic [LW-1:0]      cnt_l;
    logic [LW-1:0]      limit;
    logic signed [34:0] span;
    logic signed [34:0] lead;
    logic               ready;

    always_comb begin
        cnt_l = LW'(r_count);
        if (LW'(r_maxlen) < TWO_L) begin
            limit = TWO_L;
        end else if (LW'(r_maxlen) > DEPTH_L) begin
            limit = DEPTH_L;
        end else begin
            limit = LW'(r_maxlen);
        end
        span = $signed({3'b000, rdata.dts}) - $signed({3'b000, r_anchor_dts});
        lead = 35'(r_elapsed) - span;
        if (!r_reorder) begin
            ready = (r_count != '0);
        end else if (cnt_l < TWO_L) begin
            ready = 1'b0;
        end else begin
            ready = (cnt_l >= limit) || (lead >= $signed({19'b0, r_timeout}));
        end
    end

    // Pending and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load_pend) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.emit) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pend) begin
            r_pend <= rdata;
        end
        if (i_cmd.emit) begin
            r_out      <= r_pend;
            r_out_last <= i_cmd.emit_last;
        end
    end

    assign o_stat = '{j_zero: (r_j == '0), greater: (rdata.dts > r_item.dts),
                      ready: ready, pend_valid: r_pend_valid,
                      out_busy: (r_out_valid & ~i_out_ready),
                      full: (r_count == FULL_CNT), anchor_valid: r_anchor_valid};

    assign o_out_valid   = r_out_valid;
    assign o_out_dts     = r_out.dts;
    assign o_out_length  = r_out.len;
    assign o_out_kind    = r_out.kind;
    assign o_out_tag     = r_out.tag;
    assign o_last_of_run = r_out_last;

    `ASSERT_SAME(a_pop_nonempty, i_clk, i_rst_n, i_cmd.pop, r_count != '0, "pop from empty table")
    `ASSERT_SAME(a_emit_free, i_clk, i_rst_n, i_cmd.emit, !(r_out_valid && !i_out_ready), "emit over a stalled result")
    `ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, i_cmd.wr_new, r_count == $past(r_count) + CW'(1), "insert did not grow count")
endmodule

// File: rtl/trjq_ctrl.sv
// Controller: sequences the sorted insert and the drain run.
module trjq_ctrl import trjq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_HRD  = 3'd3;
    localparam logic [2:0] S_HCK  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [RUN_W-1:0] r_run, n_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_run   <= '0;
        end else begin
            r_state <= n_state;
            r_run   <= n_run;
        end
    end

    // Step the insert scan, then release heads while ready and under the run limit
    always_comb begin
        n_state    = r_state;
        n_run      = r_run;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_run = '0;
                    if (i_stat.full) begin
                        n_state = S_HRD;
                    end else begin
                        o_cmd.set_anchor = ~i_stat.anchor_valid;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (i_stat.j_zero) begin
                    o_cmd.wr_new = 1'b1;
                    n_state = S_HRD;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.greater) begin
                    o_cmd.wr_shift = 1'b1;
                    o_cmd.dec_j    = 1'b1;
                    n_state = S_RD;
                end else begin
                    o_cmd.wr_new = 1'b1;
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                o_cmd.rd_head = 1'b1;
                n_state = S_HCK;
            end
            S_HCK: begin
                o_cmd.rd_head = 1'b1;
                if (i_stat.ready && (r_run != RUN_W'(MAX_RUN))) begin
                    if (!(i_stat.pend_valid && i_stat.out_busy)) begin
                        o_cmd.emit      = i_stat.pend_valid;
                        o_cmd.load_pend = 1'b1;
                        o_cmd.pop       = 1'b1;
                        n_run   = r_run + RUN_W'(1);
                        n_state = S_HRD;
                    end
                end else if (i_stat.pend_valid) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// File: rtl/timestamp_reorder_jitter_queue.sv
// Top level of the timestamp reorder jitter queue.
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one packet descriptor request
//   with its local arrival time; unless the table is full, it is inserted into a
//   ring-buffer table kept sorted by timestamp, equal ones in arrival order.
//   Output channel (o_out_valid / i_out_ready) gives the released descriptors
//   oldest first; o_last_of_run marks the final one of each request's run.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// Sequencing:
//   A request is accepted in the idle state. Insert takes a RAM read, then a
//   compare and write, per entry shifted, and ends with a write of the new entry
//   from the read state at the head slot or after a compare that stops;
//   each release takes a head read then a check, and a final check ends it.
//   One request at a time: the next is accepted once this one's run is over.
// Reset clears the table count, anchor and output stage, and loads the default
//   configuration; table contents need no clearing.
// A stalled receiver holds the result in the output register; one more result
//   waits in a pending register and the drain pauses until the output frees.
module timestamp_reorder_jitter_queue import trjq_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [31:0]           i_packet_dts,
    input  logic [31:0]           i_now_time,
    input  logic [23:0]           i_packet_length,
    input  logic                  i_packet_kind,
    input  logic [15:0]           i_buffer_tag,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [31:0]           o_out_dts,
    output logic [23:0]           o_out_length,
    output logic                  o_out_kind,
    output logic [15:0]           o_out_tag,
    output logic                  o_last_of_run
);
    t_cmd  cmd;
    t_stat stat;

    trjq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    trjq_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_packet_dts    (i_packet_dts),
        .i_now_time      (i_now_time),
        .i_packet_length (i_packet_length),
        .i_packet_kind   (i_packet_kind),
        .i_buffer_tag    (i_buffer_tag),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_dts       (o_out_dts),
        .o_out_length    (o_out_length),
        .o_out_kind      (o_out_kind),
        .o_out_tag       (o_out_tag),
        .o_last_of_run   (o_last_of_run)
    );
endmodule

// File: tb/tb.sv
// Self-checking testbench of the timestamp reorder jitter queue.
`timescale 1ns / 1ps

module tb;
    import trjq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE      = 400;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        t_entry     pkt;
        logic       last;
    } t_release;

    typedef struct {
        logic [31:0] dts;
        logic [31:0] now;
        logic [23:0] len;
        logic        kind;
        logic [15:0] tag;
        int          n_rel;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [31:0]           i_packet_dts;
    logic [31:0]           i_now_time;
    logic [23:0]           i_packet_length;
    logic                  i_packet_kind;
    logic [15:0]           i_buffer_tag;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [31:0]           o_out_dts;
    logic [23:0]           o_out_length;
    logic                  o_out_kind;
    logic [15:0]           o_out_tag;
    logic                  o_last_of_run;

    // Predictor state
    t_entry      held_q[$];
    t_release    release_q[$];
    logic        anc_valid;
    logic [31:0] anc_dts;
    logic [31:0] anc_time;
    logic        cur_reorder;
    logic [15:0] cur_timeout;
    logic [6:0]  cur_maxlen;

    int  n_fail;
    int  n_sent;
    int  n_released;
    int  cycles;
    bit  calm;
    bit  long_hold_req;
    bit  long_hold;

    timestamp_reorder_jitter_queue u_dut (.*);

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Decide whether the head entry leaves at this local time
    function automatic bit head_leaves(logic [31:0] now);
        int     lim;
        longint elapsed;
        longint span;
        if (!cur_reorder) return held_q.size() > 0;
        if (held_q.size() < 2) return 1'b0;
        lim = (cur_maxlen > DEPTH) ? DEPTH : int'(cur_maxlen);
        if (held_q.size() >= lim) return 1'b1;
        elapsed = longint'({32'd0, now}) - longint'({32'd0, anc_time});
        span    = longint'({32'd0, held_q[0].dts}) - longint'({32'd0, anc_dts});
        return (elapsed - span) >= longint'({48'd0, cur_timeout});
    endfunction

    // Insert one request unless the table is full, queue the releases it causes; return their count
    function automatic int insert_and_drain(t_entry e, logic [31:0] now);
        int       pos;
        int       n;
        t_release r;
        n = 0;
        if (held_q.size() < DEPTH) begin
            if (!anc_valid) begin
                anc_valid = 1'b1;
                anc_dts   = e.dts;
                anc_time  = now;
            end
            pos = 0;
            while (pos < held_q.size() && held_q[pos].dts <= e.dts) pos++;
            held_q.insert(pos, e);
        end
        while (n < MAX_RUN && head_leaves(now)) begin
            r.pkt  = held_q.pop_front();
            r.last = 1'b0;
            release_q.push_back(r);
            n++;
        end
        if (n > 0) release_q[release_q.size() - 1].last = 1'b1;
        return n;
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_packet(t_row row);
        t_entry e;
        int     n;
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_packet_dts    <= row.dts;
        i_now_time      <= row.now;
        i_packet_length <= row.len;
        i_packet_kind   <= row.kind;
        i_buffer_tag    <= row.tag;
        do @(posedge i_clk); while (!o_in_ready);
        e.dts  = row.dts;
        e.len  = row.len;
        e.kind = row.kind;
        e.tag  = row.tag;
        n = insert_and_drain(e, row.now);
        n_sent++;
        if (row.n_rel >= 0 && n != row.n_rel) begin
            $error("release count: expected %0d, predicted %0d", row.n_rel, n);
            n_fail++;
        end
    endtask

    // Drop valid for a random burst now and then
    task automatic sender_gap();
        int g;
        if (calm || $urandom_range(0, 3) != 0) return;
        g = $urandom_range(1, 12);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (g - 1) @(negedge i_clk);
    endtask

    // Wait until every release has come out and the block has settled
    task automatic drain_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (release_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write one register
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_REORDER: cur_reorder = val[0];
            CFG_TIMEOUT: cur_timeout = val;
            CFG_MAXLEN:  cur_maxlen  = val[6:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_mode(logic reo, logic [15:0] tmo, logic [15:0] ml);
        drain_idle();
        write_reg(CFG_REORDER, {15'd0, reo});
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_MAXLEN, ml);
    endtask

    // Random stream: mostly a jittered timeline, some fully random noise
    task automatic random_stream(int count);
        logic [31:0] trend_dts;
        logic [31:0] base_now;
        int          step;
        t_row        row;
        trend_dts = ($urandom_range(0, 1) != 0) ? $urandom : 32'd0;
        base_now  = $urandom;
        for (int k = 0; k < count; k++) begin
            step      = $urandom_range(10, 40);
            trend_dts = trend_dts + step;
            base_now  = base_now + step + $urandom_range(0, 6);
            row.len   = 24'($urandom);
            row.kind  = 1'($urandom);
            row.tag   = 16'($urandom);
            row.n_rel = -1;
            if ($urandom_range(0, 9) == 0) begin
                row.dts = $urandom;
                row.now = $urandom;
            end else begin
                row.dts = trend_dts + $urandom_range(0, 200) - 100;
                row.now = base_now;
            end
            send_packet(row);
            sender_gap();
        end
    endtask

    // Receiver: random stall bursts, or the long hold-off when asked
    initial begin
        int stall;
        stall = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_ready <= 1'b0;
            end else if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                stall = $urandom_range(1, 12) - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off, counted here
    initial begin
        long_hold = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold = 1'b1;
                repeat (600) @(posedge i_clk);
                long_hold = 1'b0;
                long_hold_req = 1'b0;
            end
        end
    end

    // Compare each release against the oldest expectation
    always @(posedge i_clk) begin
        t_release r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_released++;
            if (release_q.size() == 0) begin
                $error("release with nothing expected: dts %h", o_out_dts);
                n_fail++;
            end else begin
                r = release_q.pop_front();
                if (o_out_dts !== r.pkt.dts) begin
                    $error("out_dts: expected %h, actual %h", r.pkt.dts, o_out_dts);
                    n_fail++;
                end
                if (o_out_length !== r.pkt.len) begin
                    $error("out_length: expected %h, actual %h", r.pkt.len, o_out_length);
                    n_fail++;
                end
                if (o_out_kind !== r.pkt.kind) begin
                    $error("out_kind: expected %b, actual %b", r.pkt.kind, o_out_kind);
                    n_fail++;
                end
                if (o_out_tag !== r.pkt.tag) begin
                    $error("out_tag: expected %h, actual %h", r.pkt.tag, o_out_tag);
                    n_fail++;
                end
                if (o_last_of_run !== r.last) begin
                    $error("last_of_run: expected %b, actual %b", r.last, o_last_of_run);
                    n_fail++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        static t_row rows[] = '{
            '{32'd1000,     32'd0,        24'd0,        1'b0, 16'd0,      0},
            '{32'd900,      32'd0,        24'hFFFFFF,   1'b1, 16'hFFFF,   0},
            // equal timestamps leave in arrival order
            '{32'd1000,     32'd600,      24'd5,        1'b0, 16'd1,      2},
            '{32'd0,        32'd600,      24'd6,        1'b1, 16'd2,      1},
            '{32'hFFFFFFFF, 32'd600,      24'd7,        1'b0, 16'd3,      1},
            // local time back at the anchor time
            '{32'd7,        32'd0,        24'd8,        1'b1, 16'd4,      1},
            '{32'd2000,     32'd0,        24'hAAAAAA,   1'b0, 16'h5555,  -1},
            '{32'd2000,     32'd0,        24'h555555,   1'b1, 16'hAAAA,  -1},
            '{32'd2000,     32'd0,        24'd9,        1'b0, 16'd5,     -1},
            '{32'd1500,     32'd5000,     24'd10,       1'b1, 16'd6,     -1},
            '{32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF,   1'b1, 16'hFFFF,  -1},
            '{32'h80000000, 32'h7FFFFFFF, 24'h800000,   1'b0, 16'h8000,  -1},
            '{32'h12345678, 32'hFFFFFFFF, 24'h123456,   1'b1, 16'h1234,  -1}
        };
        n_fail = 0;
        n_sent = 0;
        n_released = 0;
        calm = 1'b0;
        long_hold_req = 1'b0;
        anc_valid = 1'b0;
        anc_dts = '0;
        anc_time = '0;
        cur_reorder = 1'b1;
        cur_timeout = RST_TIMEOUT;
        cur_maxlen = RST_MAXLEN;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_packet_dts = '0;
        i_now_time = '0;
        i_packet_length = '0;
        i_packet_kind = 1'b0;
        i_buffer_tag = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset configuration; an unused index is ignored
        write_reg(CFG_UNUSED, 16'hFFFF);
        foreach (rows[k]) begin
            send_packet(rows[k]);
            sender_gap();
        end

        // Random phases across the register extremes
        set_mode(1'b1, 16'd0, 16'd2);
        random_stream(50);
        set_mode(1'b1, 16'hFFFF, 16'd64);
        random_stream(80);
        set_mode(1'b0, 16'd100, 16'd10);
        long_hold_req = 1'b1;
        random_stream(50);
        set_mode(1'b1, 16'd200, 16'd127);
        random_stream(50);
        set_mode(1'b1, 16'd30, 16'd0);
        random_stream(50);
        set_mode(1'b1, 16'd1000, 16'd8);
        calm = 1'b1;
        random_stream(100);

        drain_idle();
        $display("covered %0d requests, %0d releases, six register settings", n_sent,
                 n_released);
        $display("including reorder off, timeout and length extremes, long output stall");
        if (n_fail == 0 && release_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
